/* design/scale_weight_frame_parser_core_assert.svh */
// Assertion macros for the scale weight frame parser.
`ifndef SCALE_WEIGHT_FRAME_PARSER_CORE_ASSERT_SVH
`define SCALE_WEIGHT_FRAME_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define SWFP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while in reset.
`define SWFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/swfp_pkg.sv */
`timescale 1ns / 1ps

package swfp_pkg;

    localparam logic [7:0] HDR0       = 8'h01;
    localparam logic [7:0] HDR1       = 8'h02;
    localparam logic [7:0] MINUS_SIGN = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [4:0] POS_HDR0       = 5'd0;
    localparam logic [4:0] POS_HDR1       = 5'd1;
    localparam logic [4:0] POS_SIGN       = 5'd2;
    localparam logic [4:0] POS_DIGIT_LAST = 5'd8;
    localparam logic [4:0] POS_BATT       = 5'd15;
    localparam logic [4:0] POS_MAX        = 5'd31;

    // battery: floor((raw - 129) * 100 / 29), 100 * 2^16 / 29 rounded up
    localparam logic [7:0]  BATT_BASE  = 8'd129;
    localparam logic [7:0]  BATT_FULL  = 8'd158;
    localparam logic [6:0]  PCT_FULL   = 7'd100;
    localparam logic [17:0] BATT_RECIP = 18'd225987;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_SHORT      = 2'd1,
        STATUS_BAD_HEADER = 2'd2,
        STATUS_BAD_DIGIT  = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } beat_t;

    typedef struct packed {
        status_t            status;
        logic signed [20:0] weight_centigrams;
        logic               battery_present;
        logic [6:0]         battery_percent;
    } result_t;

    function automatic logic [6:0] battery_level(input logic [7:0] raw);
        logic [4:0]  diff;
        logic [22:0] prod;
        diff = 5'(raw - BATT_BASE);
        prod = 23'(diff) * 23'(BATT_RECIP);
        if (raw <= BATT_BASE) begin
            return 7'd0;
        end else if (raw >= BATT_FULL) begin
            return PCT_FULL;
        end else begin
            return prod[22:16];
        end
    endfunction

endpackage

/* design/swfp_in_stage.sv */
`timescale 1ns / 1ps

module swfp_in_stage
    import swfp_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  beat_t in_beat,
    input  logic  take,
    output logic  beat_valid,
    output beat_t beat
);

    logic  valid_reg;
    beat_t beat_reg;

    assign in_ready   = !valid_reg || take;
    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_valid && in_ready) begin
            valid_reg <= 1'b1;
        end else if (take) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            beat_reg <= in_beat;
        end
    end

endmodule

/* design/swfp_frame.sv */
`timescale 1ns / 1ps

module swfp_frame
    import swfp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    take,
    input  beat_t   beat,
    output logic    result_valid,
    output result_t result
);

    logic [4:0]  pos_reg, pos_next;
    logic        header_bad_reg, header_bad_next;
    logic        negative_reg, negative_next;
    logic [19:0] acc_reg, acc_next;
    logic        digit_bad_reg, digit_bad_next;
    logic [6:0]  batt_pct_reg, batt_pct_next;

    logic        is_digit;
    logic [3:0]  digit;
    logic        ok;
    logic [20:0] magnitude;

    assign is_digit     = (beat.data_byte >= CHAR_ZERO) && (beat.data_byte <= CHAR_NINE);
    assign digit        = 4'(beat.data_byte - CHAR_ZERO);
    assign result_valid = take && beat.last_byte;

    always_comb begin
        pos_next        = (pos_reg == POS_MAX) ? POS_MAX : 5'(pos_reg + 5'd1);
        header_bad_next = header_bad_reg;
        negative_next   = negative_reg;
        acc_next        = acc_reg;
        digit_bad_next  = digit_bad_reg;
        batt_pct_next   = batt_pct_reg;

        priority if (pos_reg == POS_HDR0) begin
            if (beat.data_byte != HDR0) header_bad_next = 1'b1;
        end else if (pos_reg == POS_HDR1) begin
            if (beat.data_byte != HDR1) header_bad_next = 1'b1;
        end else if (pos_reg == POS_SIGN) begin
            negative_next = (beat.data_byte == MINUS_SIGN);
        end else if (pos_reg <= POS_DIGIT_LAST) begin
            if (is_digit) begin
                acc_next = 20'({acc_reg, 3'b000} + {acc_reg, 1'b0} + 23'(digit));
            end else begin
                digit_bad_next = 1'b1;
            end
        end else if (pos_reg == POS_BATT) begin
            batt_pct_next = battery_level(beat.data_byte);
        end else begin
            batt_pct_next = batt_pct_reg;
        end

        priority if (pos_reg < POS_DIGIT_LAST) begin
            result.status = STATUS_SHORT;
        end else if (header_bad_next) begin
            result.status = STATUS_BAD_HEADER;
        end else if (digit_bad_next) begin
            result.status = STATUS_BAD_DIGIT;
        end else begin
            result.status = STATUS_OK;
        end

        ok        = (result.status == STATUS_OK);
        magnitude = {1'b0, acc_next};
        result.weight_centigrams = !ok          ? 21'sd0 :
                                   negative_next ? -$signed(magnitude) : $signed(magnitude);
        result.battery_present   = ok && (pos_reg >= POS_BATT);
        result.battery_percent   = result.battery_present ? batt_pct_next : 7'd0;

        if (beat.last_byte) begin
            pos_next        = 5'd0;
            header_bad_next = 1'b0;
            negative_next   = 1'b0;
            acc_next        = 20'd0;
            digit_bad_next  = 1'b0;
            batt_pct_next   = 7'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= 5'd0;
            header_bad_reg <= 1'b0;
            negative_reg   <= 1'b0;
            acc_reg        <= 20'd0;
            digit_bad_reg  <= 1'b0;
            batt_pct_reg   <= 7'd0;
        end else if (take) begin
            pos_reg        <= pos_next;
            header_bad_reg <= header_bad_next;
            negative_reg   <= negative_next;
            acc_reg        <= acc_next;
            digit_bad_reg  <= digit_bad_next;
            batt_pct_reg   <= batt_pct_next;
        end
    end

endmodule

/* design/swfp_out_stage.sv */
`timescale 1ns / 1ps

module swfp_out_stage
    import swfp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  result_t result,
    output logic    room,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_result
);

    logic    valid_reg;
    result_t result_reg;

    assign room       = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

endmodule

/* design/scale_weight_frame_parser_core.sv */
`timescale 1ns / 1ps
// Channel   Dir  Beat contents
// s_        in   tdata: data_byte, tlast: last_byte
// m_        out  tdata: weight, battery percent; tuser: status, battery present
//
// One byte a cycle unless a final byte stalls; m_tvalid comes from the result register.
// Input register, then the frame state update, then the result register.
// aresetn is synchronous, active low, and clears the frame state.
// A stalled result holds the pipe only when a final byte is waiting behind it.

`include "scale_weight_frame_parser_core_assert.svh"

module scale_weight_frame_parser_core
    import swfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [20:0] weight_centigrams, [27:21] battery_percent
    output logic [2:0]  m_tuser    // [1:0] status, [2] battery_present
);

    beat_t   in_beat;
    beat_t   beat;
    logic    beat_valid;
    logic    take;
    logic    room;
    logic    result_valid;
    result_t result;
    result_t out_result;

    assign in_beat.data_byte = s_tdata;
    assign in_beat.last_byte = s_tlast;
    assign take = beat_valid && (!beat.last_byte || room);

    swfp_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_beat    (in_beat),
        .take       (take),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    swfp_frame u_frame (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .take         (take),
        .beat         (beat),
        .result_valid (result_valid),
        .result       (result)
    );

    swfp_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (result_valid),
        .result     (result),
        .room       (room),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (out_result)
    );

    assign m_tdata = {4'd0, out_result.battery_percent, out_result.weight_centigrams};
    assign m_tuser = {out_result.battery_present, out_result.status};

    `SWFP_ASSERT_NOW(a_err_clear, m_tvalid && (out_result.status != STATUS_OK),
        (out_result.weight_centigrams == 21'sd0) && !out_result.battery_present,
        "failed frame carries data")
    `SWFP_ASSERT_NOW(a_batt_range, m_tvalid, out_result.battery_percent <= PCT_FULL, "battery percent above full")
    `SWFP_ASSERT_NEXT(a_last_result, take && beat.last_byte, m_tvalid, "final byte gave no result")
    `SWFP_ASSERT_NOW(a_take_room, take && beat.last_byte, room, "result register overwritten")

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import swfp_pkg::*;

    localparam int unsigned MIN_FRAME_LEN  = 9;
    localparam int unsigned BATT_FRAME_LEN = 16;
    localparam int unsigned BATT_SPAN      = 29;
    localparam int unsigned PHASE_BEATS    = 165;
    localparam int unsigned CYCLE_LIMIT    = 200000;

    typedef struct {
        logic [7:0] b;
        logic       l;
        bit         typed;
        result_t    res;
    } dir_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;

    int unsigned src_idle_pct = 0;
    int unsigned rcv_idle_pct = 0;
    int unsigned beats_sent   = 0;
    int unsigned errors       = 0;
    int unsigned cycles       = 0;

    // frame tracking state
    logic [4:0]  frm_pos       = '0;
    logic        frm_hdr_bad   = 1'b0;
    logic        frm_neg       = 1'b0;
    logic [19:0] frm_acc       = '0;
    logic        frm_digit_bad = 1'b0;
    logic [7:0]  frm_batt_raw  = '0;

    result_t  readings_due[$];
    dir_row_t dir_rows[$];

    scale_weight_frame_parser_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [7:0] data_byte
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [20:0] weight_centigrams, [27:21] battery_percent
        .m_tuser  (m_tuser)    // [1:0] status, [2] battery_present
    );

    always #5 aclk = ~aclk;

    function automatic logic [6:0] battery_pct_of(input logic [7:0] raw);
        int unsigned p;
        if (raw <= BATT_BASE) begin
            return 7'd0;
        end
        p = ((int'(raw) - int'(BATT_BASE)) * 100) / BATT_SPAN;
        return (p > 100) ? PCT_FULL : 7'(p);
    endfunction

    function automatic bit predict_byte(input logic [7:0] b, input logic l, output result_t r);
        int unsigned frame_len;
        r = '0;
        if (frm_pos == POS_HDR0) begin
            if (b != HDR0) frm_hdr_bad = 1'b1;
        end else if (frm_pos == POS_HDR1) begin
            if (b != HDR1) frm_hdr_bad = 1'b1;
        end else if (frm_pos == POS_SIGN) begin
            frm_neg = (b == MINUS_SIGN);
        end else if (frm_pos <= POS_DIGIT_LAST) begin
            if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
                frm_acc = 20'(frm_acc * 10 + (b - CHAR_ZERO));
            end else begin
                frm_digit_bad = 1'b1;
            end
        end else if (frm_pos == POS_BATT) begin
            frm_batt_raw = b;
        end
        frame_len = int'(frm_pos) + 1;
        frm_pos = (frm_pos < POS_MAX) ? frm_pos + 5'd1 : POS_MAX;
        if (!l) begin
            return 1'b0;
        end
        if (frame_len < MIN_FRAME_LEN) begin
            r.status = STATUS_SHORT;
        end else if (frm_hdr_bad) begin
            r.status = STATUS_BAD_HEADER;
        end else if (frm_digit_bad) begin
            r.status = STATUS_BAD_DIGIT;
        end else begin
            r.status = STATUS_OK;
            r.weight_centigrams = frm_neg ? -$signed({1'b0, frm_acc}) : $signed({1'b0, frm_acc});
            if (frame_len >= BATT_FRAME_LEN) begin
                r.battery_present = 1'b1;
                r.battery_percent = battery_pct_of(frm_batt_raw);
            end
        end
        frm_pos       = '0;
        frm_hdr_bad   = 1'b0;
        frm_neg       = 1'b0;
        frm_acc       = '0;
        frm_digit_bad = 1'b0;
        frm_batt_raw  = '0;
        return 1'b1;
    endfunction

    function automatic result_t mk_reading(input status_t st, input int w, input logic p,
                                           input int pct);
        result_t r;
        r.status            = st;
        r.weight_centigrams = 21'(w);
        r.battery_present   = p;
        r.battery_percent   = 7'(pct);
        return r;
    endfunction

    task automatic add_row(input logic [7:0] b, input logic l, input bit typed, input result_t res);
        dir_row_t row;
        row.b     = b;
        row.l     = l;
        row.typed = typed;
        row.res   = res;
        dir_rows.push_back(row);
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycles, msg);
        errors++;
    endtask

    task automatic send_beat(input logic [7:0] b, input logic l, input bit typed,
                             input result_t typed_res);
        result_t r;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= l;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (predict_byte(b, l, r)) begin
            readings_due.push_back(typed ? typed_res : r);
        end
        beats_sent++;
    endtask

    task automatic send_random_frame();
        logic [7:0]  fb [40];
        int unsigned len;
        int unsigned dmode;
        int unsigned pick;
        int unsigned k;
        int unsigned p;
        logic [7:0]  v;
        result_t     none;
        none  = '0;
        dmode = $urandom_range(0, 99);
        for (k = 0; k < 40; k++) begin
            fb[k] = 8'($urandom_range(0, 255));
        end
        fb[POS_HDR0] = HDR0;
        fb[POS_HDR1] = HDR1;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            fb[POS_SIGN] = MINUS_SIGN;
        end else if (pick < 70) begin
            fb[POS_SIGN] = 8'h2B;
        end
        for (k = 3; k <= POS_DIGIT_LAST; k++) begin
            if (dmode < 15) begin
                fb[k] = CHAR_ZERO;
            end else if (dmode < 25) begin
                fb[k] = CHAR_NINE;
            end else begin
                fb[k] = CHAR_ZERO + 8'($urandom_range(0, 9));
            end
        end
        if ($urandom_range(0, 1) == 0) begin
            fb[POS_BATT] = 8'($urandom_range(125, 162));
        end
        // broken frames
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            p = $urandom_range(0, 1);
            fb[p] = fb[p] ^ 8'($urandom_range(1, 255));
        end else if (pick < 16) begin
            p = $urandom_range(3, POS_DIGIT_LAST);
            case ($urandom_range(0, 2))
                0: fb[p] = 8'h2F;
                1: fb[p] = 8'h3A;
                default: begin
                    v = 8'($urandom_range(0, 255));
                    if (v >= CHAR_ZERO && v <= CHAR_NINE) v = v ^ 8'h40;
                    fb[p] = v;
                end
            endcase
        end else if (pick < 22) begin
            for (k = 0; k < 40; k++) begin
                fb[k] = 8'($urandom_range(0, 255));
            end
        end
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            len = $urandom_range(1, 8);
        end else if (pick < 55) begin
            len = $urandom_range(9, 15);
        end else if (pick < 85) begin
            len = $urandom_range(16, 20);
        end else begin
            len = $urandom_range(21, 40);
        end
        for (k = 0; k < len; k++) begin
            send_beat(fb[k], (k == len - 1), 1'b0, none);
        end
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("scale_weight_frame_parser_core verification failed");
            $finish;
        end
    end

    always @(posedge aclk) begin : result_check
        result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (readings_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result tdata %h tuser %h",
                                          m_tdata, m_tuser));
            end else begin
                exp_r = readings_due.pop_front();
                if (m_tuser[1:0] != exp_r.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              m_tuser[1:0], exp_r.status));
                if (m_tdata[20:0] != exp_r.weight_centigrams)
                    report_mismatch($sformatf("weight %0d, want %0d",
                                              $signed(m_tdata[20:0]),
                                              exp_r.weight_centigrams));
                if (m_tuser[2] != exp_r.battery_present)
                    report_mismatch($sformatf("battery_present %0d, want %0d",
                                              m_tuser[2], exp_r.battery_present));
                if (m_tdata[27:21] != exp_r.battery_percent)
                    report_mismatch($sformatf("battery_percent %0d, want %0d",
                                              m_tdata[27:21], exp_r.battery_percent));
            end
        end
    end

    initial begin : stimulus
        int unsigned i;
        result_t     none;
        none = '0;
        src_idle_pct = 18;
        rcv_idle_pct = 49;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // single byte frame
        add_row(8'hFF, 1'b1, 1'b1, mk_reading(STATUS_SHORT, 0, 1'b0, 0));
        // full scale negative, battery byte at top
        add_row(HDR0, 1'b0, 1'b0, none);
        add_row(HDR1, 1'b0, 1'b0, none);
        add_row(MINUS_SIGN, 1'b0, 1'b0, none);
        add_row(CHAR_NINE, 1'b0, 1'b0, none);
        add_row(CHAR_NINE, 1'b0, 1'b0, none);
        add_row(CHAR_NINE, 1'b0, 1'b0, none);
        add_row(CHAR_NINE, 1'b0, 1'b0, none);
        add_row(CHAR_NINE, 1'b0, 1'b0, none);
        add_row(CHAR_NINE, 1'b0, 1'b0, none);
        add_row(8'h00, 1'b0, 1'b0, none);
        add_row(8'hFF, 1'b0, 1'b0, none);
        add_row(8'h80, 1'b0, 1'b0, none);
        add_row(8'h7F, 1'b0, 1'b0, none);
        add_row(8'h55, 1'b0, 1'b0, none);
        add_row(8'hAA, 1'b0, 1'b0, none);
        add_row(8'hFF, 1'b1, 1'b1, mk_reading(STATUS_OK, -999999, 1'b1, 100));
        // minimum length, non-digit in last digit slot
        add_row(HDR0, 1'b0, 1'b0, none);
        add_row(HDR1, 1'b0, 1'b0, none);
        add_row(8'h2B, 1'b0, 1'b0, none);
        add_row(CHAR_ZERO, 1'b0, 1'b0, none);
        add_row(CHAR_ZERO, 1'b0, 1'b0, none);
        add_row(CHAR_ZERO, 1'b0, 1'b0, none);
        add_row(CHAR_ZERO, 1'b0, 1'b0, none);
        add_row(CHAR_ZERO, 1'b0, 1'b0, none);
        add_row(8'h3A, 1'b1, 1'b1, mk_reading(STATUS_BAD_DIGIT, 0, 1'b0, 0));

        for (i = 0; i < dir_rows.size(); i++) begin
            send_beat(dir_rows[i].b, dir_rows[i].l, dir_rows[i].typed, dir_rows[i].res);
        end

        while (beats_sent < PHASE_BEATS) send_random_frame();
        src_idle_pct = 49;
        rcv_idle_pct = 18;
        while (beats_sent < 2 * PHASE_BEATS) send_random_frame();
        src_idle_pct = 0;
        rcv_idle_pct = 0;
        while (beats_sent < 3 * PHASE_BEATS) send_random_frame();

        s_tvalid <= 1'b0;
        while (readings_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (errors == 0) begin
            $display("scale_weight_frame_parser_core verification clean");
        end else begin
            $display("scale_weight_frame_parser_core verification failed");
        end
        $finish;
    end

endmodule
